FILE: sv/dmac_pkg.sv
package dmac_pkg;

   // copy geometry
   localparam int BURST_WORDS = 16;
   localparam int WORD_BYTES  = 4;
   localparam int BCNT_W      = $clog2(BURST_WORDS + 1);
   localparam int BIDX_W      = (BURST_WORDS > 1) ? $clog2(BURST_WORDS) : 1;

   // input command codes
   localparam logic [1:0] CMD_REG_READ  = 2'd0;
   localparam logic [1:0] CMD_REG_WRITE = 2'd1;
   localparam logic [1:0] CMD_MEM_DATA  = 2'd2;

   // register byte offsets
   localparam logic [5:0] OFF_SRC  = 6'd0;
   localparam logic [5:0] OFF_DST  = 6'd4;
   localparam logic [5:0] OFF_LEN  = 6'd8;
   localparam logic [5:0] OFF_BIAS = 6'd12;
   localparam logic [5:0] OFF_CTL  = 6'd16;
   localparam logic [5:0] OFF_MON1 = 6'd20;
   localparam logic [5:0] OFF_MON2 = 6'd24;
   localparam logic [5:0] OFF_MON3 = 6'd28;
   localparam logic [5:0] OFF_MON4 = 6'd32;

   // access sizes
   localparam logic [3:0] SIZE_CTL  = 4'd1;
   localparam logic [3:0] SIZE_WORD = 4'd4;

   // control register bits
   localparam int CTL_START_BIT = 0;
   localparam int CTL_IRQ_BIT   = 4;

   typedef enum logic [1:0] {
      KIND_REG  = 2'd0,
      KIND_REQ  = 2'd1,
      KIND_WORD = 2'd2
   } dmac_kind_type;

   // controller to datapath
   typedef struct packed {
      logic          accept;
      logic          load;
      dmac_kind_type kind;
      logic          last;
   } dmac_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_reg;
      logic kick_req;
      logic burst_done;
      logic burst_ok;
      logic burst_more;
      logic last_word;
   } dmac_status_type;

endpackage

FILE: sv/dmac_ctrl.sv
module dmac_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  dmac_pkg::dmac_status_type status,
   output dmac_pkg::dmac_cmd_type    cmd
);
   import dmac_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REG_RSP,
      ST_PREP,
      ST_WR_EMIT,
      ST_REQ
   } state_type;

   state_type state_ff, state_in;
   logic      need_req_ff, need_req_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in    = state_ff;
      need_req_in = need_req_ff;
      cmd.accept  = 1'b0;
      cmd.load    = 1'b0;
      cmd.kind    = KIND_REG;
      cmd.last    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            cmd.accept = req_valid;
            if (req_valid) begin
               if (status.is_reg) begin
                  state_in    = ST_REG_RSP;
                  need_req_in = status.kick_req;
               end else if (status.burst_done) begin
                  need_req_in = status.burst_more;
                  if (status.burst_ok) begin
                     state_in = ST_PREP;
                  end else if (status.burst_more) begin
                     state_in = ST_REQ;
                  end
               end
            end
         end
         ST_REG_RSP: begin
            if (out_free) begin
               cmd.load = 1'b1;
               cmd.kind = KIND_REG;
               cmd.last = !need_req_ff;
               state_in = need_req_ff ? ST_REQ : ST_IDLE;
            end
         end
         ST_PREP: begin
            // buffer read of the first word
            state_in = ST_WR_EMIT;
         end
         ST_WR_EMIT: begin
            if (out_free) begin
               cmd.load = 1'b1;
               cmd.kind = KIND_WORD;
               cmd.last = status.last_word && !need_req_ff;
               if (status.last_word) begin
                  state_in = need_req_ff ? ST_REQ : ST_IDLE;
               end
            end
         end
         ST_REQ: begin
            if (out_free) begin
               cmd.load = 1'b1;
               cmd.kind = KIND_REQ;
               cmd.last = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
      end else if (out_free) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         need_req_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         need_req_ff  <= need_req_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTH
   a_reg_goes_to_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.accept && status.is_reg |=> state_ff == ST_REG_RSP)
      else $error("register access did not move to response");
   a_last_word_ends: assert property (@(posedge clock) disable iff (reset)
      cmd.load && cmd.kind == KIND_WORD && status.last_word && !need_req_ff
      |=> state_ff == ST_IDLE)
      else $error("final write word did not end the item");
   a_stalled_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff)
      else $error("stalled result dropped");
`endif

endmodule

FILE: sv/dmac_datapath.sv
module dmac_datapath (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [1:0]                req_command,
   input  logic [5:0]                req_reg_offset,
   input  logic [3:0]                req_access_size,
   input  logic [31:0]               req_write_data,
   input  logic [31:0]               req_mem_word,
   input  logic                      req_mem_ok,
   input  dmac_pkg::dmac_cmd_type    cmd,
   output dmac_pkg::dmac_status_type status,
   output logic [1:0]                rsp_result_kind,
   output logic [31:0]               rsp_read_data,
   output logic                      rsp_bus_error,
   output logic [31:0]               rsp_mem_address,
   output logic [4:0]                rsp_burst_words,
   output logic [31:0]               rsp_write_word,
   output logic                      rsp_last,
   output logic                      rsp_irq_level,
   output logic                      rsp_busy_res
);
   import dmac_pkg::*;

   // register file and copy state
   logic [31:0]       src_ff, src_in, dst_ff, dst_in, len_ff, len_in, bias_ff, bias_in;
   logic [31:0]       mon1_ff, mon1_in, mon2_ff, mon2_in, mon3_ff, mon3_in, mon4_ff, mon4_in;
   logic              start_ff, start_in, irq_ff, irq_in;
   logic [31:0]       rcur_ff, rcur_in, wcur_ff, wcur_in;
   logic [30:0]       words_ff, words_in;
   logic [BCNT_W-1:0] fill_ff, fill_in;
   logic              failed_ff, failed_in;

   // emission state
   logic [31:0]       rd_ff, rd_in;
   logic              err_ff, err_in;
   logic [31:0]       waddr_ff, waddr_in;
   logic [BCNT_W-1:0] idx_ff, idx_in, cnt_ff, cnt_in;

   // response register
   logic [1:0]        kind_ff, kind_in;
   logic [31:0]       rdata_ff, rdata_in, maddr_ff, maddr_in, wword_ff, wword_in;
   logic [4:0]        bw_ff, bw_in;
   logic              berr_ff, berr_in, last_ff, last_in, irqo_ff, irqo_in, busy_ff, busy_in;

   // burst buffer
   logic [31:0]       buf_mem [BURST_WORDS];
   logic [31:0]       buf_q_ff;

   logic              is_write, off_ok, reg_err, kick, take_word;
   logic [3:0]        size_need;
   logic [32:0]       len_ext;
   logic [30:0]       words_new;
   logic [BCNT_W-1:0] blen;
   logic [31:0]       blen_bytes, read_mux;
   logic [7:0]        ctl_byte;

   assign is_write  = (req_command == CMD_REG_WRITE);
   assign size_need = (req_reg_offset == OFF_CTL) ? SIZE_CTL : SIZE_WORD;
   assign off_ok    = (req_reg_offset[1:0] == 2'b00) && (req_reg_offset <= OFF_MON4);
   assign reg_err   = !off_ok || (req_access_size != size_need);
   assign kick      = is_write && !reg_err && (req_reg_offset == OFF_CTL)
                      && req_write_data[CTL_START_BIT] && !start_ff;
   assign len_ext   = {1'b0, len_ff} + 33'(WORD_BYTES - 1);
   assign words_new = 31'(len_ext / 33'(WORD_BYTES));
   assign blen      = (words_ff < 31'(BURST_WORDS)) ? words_ff[BCNT_W-1:0]
                                                    : BCNT_W'(BURST_WORDS);
   assign blen_bytes = 32'(blen) * 32'(WORD_BYTES);
   assign take_word = (req_command == CMD_MEM_DATA) && start_ff && (blen != '0)
                      && (fill_ff < blen);
   assign ctl_byte  = 8'((32'(irq_ff) << CTL_IRQ_BIT) | (32'(start_ff) << CTL_START_BIT));

   assign status.is_reg     = (req_command == CMD_REG_READ) || is_write;
   assign status.kick_req   = kick && (words_new != '0);
   assign status.burst_done = take_word && (fill_ff + 1'b1 == blen);
   assign status.burst_ok   = !failed_ff && req_mem_ok;
   assign status.burst_more = (words_ff != 31'(blen));
   assign status.last_word  = (idx_ff == cnt_ff - 1'b1);

   always_comb begin
      case (req_reg_offset)
         OFF_SRC:  read_mux = src_ff;
         OFF_DST:  read_mux = dst_ff;
         OFF_LEN:  read_mux = len_ff;
         OFF_BIAS: read_mux = bias_ff;
         OFF_CTL:  read_mux = 32'(ctl_byte);
         OFF_MON1: read_mux = {24'd0, mon1_ff[7:0]};
         OFF_MON2: read_mux = mon2_ff;
         OFF_MON3: read_mux = {24'd0, mon3_ff[7:0]};
         OFF_MON4: read_mux = {24'd0, mon4_ff[7:0]};
         default:  read_mux = 32'd0;
      endcase
   end

   always_comb begin
      src_in    = src_ff;
      dst_in    = dst_ff;
      len_in    = len_ff;
      bias_in   = bias_ff;
      mon1_in   = mon1_ff;
      mon2_in   = mon2_ff;
      mon3_in   = mon3_ff;
      mon4_in   = mon4_ff;
      start_in  = start_ff;
      irq_in    = irq_ff;
      rcur_in   = rcur_ff;
      wcur_in   = wcur_ff;
      words_in  = words_ff;
      fill_in   = fill_ff;
      failed_in = failed_ff;
      rd_in     = rd_ff;
      err_in    = err_ff;
      waddr_in  = waddr_ff;
      idx_in    = idx_ff;
      cnt_in    = cnt_ff;

      if (cmd.accept && status.is_reg) begin
         rd_in  = (is_write || reg_err) ? 32'd0 : read_mux;
         err_in = reg_err;
         if (is_write && !reg_err) begin
            case (req_reg_offset)
               OFF_SRC:  src_in  = req_write_data;
               OFF_DST:  dst_in  = req_write_data;
               OFF_LEN:  len_in  = req_write_data;
               OFF_BIAS: bias_in = req_write_data;
               OFF_CTL: begin
                  if (!req_write_data[CTL_IRQ_BIT]) begin
                     irq_in = 1'b0;
                  end
                  if (kick) begin
                     rcur_in   = src_ff;
                     wcur_in   = dst_ff;
                     words_in  = words_new;
                     fill_in   = '0;
                     failed_in = 1'b0;
                     start_in  = (words_new != '0);
                     // empty copy finishes at once
                     if (words_new == '0) begin
                        irq_in = 1'b1;
                     end
                  end
               end
               OFF_MON1: mon1_in = req_write_data;
               OFF_MON2: mon2_in = req_write_data;
               OFF_MON3: mon3_in = req_write_data;
               OFF_MON4: mon4_in = req_write_data;
               default: begin
               end
            endcase
         end
      end

      if (cmd.accept && take_word) begin
         if (status.burst_done) begin
            fill_in   = '0;
            failed_in = 1'b0;
            rcur_in   = rcur_ff + blen_bytes;
            wcur_in   = wcur_ff + blen_bytes;
            words_in  = words_ff - 31'(blen);
            waddr_in  = wcur_ff;
            cnt_in    = blen;
            idx_in    = '0;
            if (!status.burst_more) begin
               start_in = 1'b0;
               irq_in   = 1'b1;
            end
         end else begin
            fill_in   = fill_ff + 1'b1;
            failed_in = failed_ff || !req_mem_ok;
         end
      end

      if (cmd.load && cmd.kind == KIND_WORD) begin
         idx_in   = idx_ff + 1'b1;
         waddr_in = waddr_ff + 32'(WORD_BYTES);
      end
   end

   always_comb begin
      kind_in  = kind_ff;
      rdata_in = rdata_ff;
      berr_in  = berr_ff;
      maddr_in = maddr_ff;
      bw_in    = bw_ff;
      wword_in = wword_ff;
      last_in  = last_ff;
      irqo_in  = irqo_ff;
      busy_in  = busy_ff;
      if (cmd.load) begin
         kind_in  = cmd.kind;
         rdata_in = 32'd0;
         berr_in  = 1'b0;
         maddr_in = 32'd0;
         bw_in    = 5'd0;
         wword_in = 32'd0;
         last_in  = cmd.last;
         irqo_in  = irq_ff;
         busy_in  = start_ff;
         case (cmd.kind)
            KIND_REG: begin
               rdata_in = rd_ff;
               berr_in  = err_ff;
            end
            KIND_REQ: begin
               maddr_in = rcur_ff;
               bw_in    = 5'(blen);
            end
            KIND_WORD: begin
               maddr_in = waddr_ff;
               wword_in = buf_q_ff;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_ff    <= '0;
         dst_ff    <= '0;
         len_ff    <= '0;
         bias_ff   <= '0;
         mon1_ff   <= '0;
         mon2_ff   <= '0;
         mon3_ff   <= '0;
         mon4_ff   <= '0;
         start_ff  <= 1'b0;
         irq_ff    <= 1'b0;
         rcur_ff   <= '0;
         wcur_ff   <= '0;
         words_ff  <= '0;
         fill_ff   <= '0;
         failed_ff <= 1'b0;
      end else begin
         src_ff    <= src_in;
         dst_ff    <= dst_in;
         len_ff    <= len_in;
         bias_ff   <= bias_in;
         mon1_ff   <= mon1_in;
         mon2_ff   <= mon2_in;
         mon3_ff   <= mon3_in;
         mon4_ff   <= mon4_in;
         start_ff  <= start_in;
         irq_ff    <= irq_in;
         rcur_ff   <= rcur_in;
         wcur_ff   <= wcur_in;
         words_ff  <= words_in;
         fill_ff   <= fill_in;
         failed_ff <= failed_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ff    <= rd_in;
      err_ff   <= err_in;
      waddr_ff <= waddr_in;
      idx_ff   <= idx_in;
      cnt_ff   <= cnt_in;
      kind_ff  <= kind_in;
      rdata_ff <= rdata_in;
      berr_ff  <= berr_in;
      maddr_ff <= maddr_in;
      bw_ff    <= bw_in;
      wword_ff <= wword_in;
      last_ff  <= last_in;
      irqo_ff  <= irqo_in;
      busy_ff  <= busy_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && take_word) begin
         buf_mem[fill_ff[BIDX_W-1:0]] <= req_mem_word;
      end
      buf_q_ff <= buf_mem[idx_in[BIDX_W-1:0]];
   end

   assign rsp_result_kind = kind_ff;
   assign rsp_read_data   = rdata_ff;
   assign rsp_bus_error   = berr_ff;
   assign rsp_mem_address = maddr_ff;
   assign rsp_burst_words = bw_ff;
   assign rsp_write_word  = wword_ff;
   assign rsp_last        = last_ff;
   assign rsp_irq_level   = irqo_ff;
   assign rsp_busy_res    = busy_ff;

`ifndef SYNTH
   a_busy_has_words: assert property (@(posedge clock) disable iff (reset)
      start_ff |-> words_ff != '0)
      else $error("copy busy with no words left");
   a_idle_fill_empty: assert property (@(posedge clock) disable iff (reset)
      !start_ff |-> fill_ff == '0)
      else $error("burst fill nonzero while idle");
   a_fill_in_burst: assert property (@(posedge clock) disable iff (reset)
      start_ff |-> fill_ff < blen)
      else $error("burst fill beyond burst length");
`endif

endmodule

FILE: sv/register_mapped_dma_copy_engine.sv
// channel   | handshake                    | payload
// ----------+------------------------------+---------------------------------------------
// req (in)  | req_valid / req_stall        | command, reg_offset, access_size, write_data,
//           |                              | mem_word, mem_ok
// rsp (out) | rsp_valid / rsp_stall        | result_kind, read_data, bus_error, mem_address,
//           |                              | burst_words, write_word, last, irq_level, busy_res
//
// one item at a time: a new transfer is taken only once the previous item's last result
// sits in the output register
// register access: the response is emitted from ST_REG_RSP, then a burst request when START kicks
// a returned word that does not finish a burst gives no result
// a burst's last word: buffer read set-up in ST_PREP, then one write word per cycle while
// rsp_stall allows (none for a failed burst), then a burst request if words remain; the
// registered burst buffer read sets the set-up; reset clears the register file, flags and
// cursors; rsp_stall holds the output register and pauses emission
module register_mapped_dma_copy_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic [5:0]  req_reg_offset,
   input  logic [3:0]  req_access_size,
   input  logic [31:0] req_write_data,
   input  logic [31:0] req_mem_word,
   input  logic        req_mem_ok,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_result_kind,
   output logic [31:0] rsp_read_data,
   output logic        rsp_bus_error,
   output logic [31:0] rsp_mem_address,
   output logic [4:0]  rsp_burst_words,
   output logic [31:0] rsp_write_word,
   output logic        rsp_last,
   output logic        rsp_irq_level,
   output logic        rsp_busy_res
);
   import dmac_pkg::*;

   // command from the sequencer, status back from the register and copy datapath
   dmac_cmd_type    cmd;
   dmac_status_type status;

   // sequencer: takes transfers, orders the response, write words and burst request
   dmac_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: register file, cursors, burst buffer and output payload register
   dmac_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_command     (req_command),
      .req_reg_offset  (req_reg_offset),
      .req_access_size (req_access_size),
      .req_write_data  (req_write_data),
      .req_mem_word    (req_mem_word),
      .req_mem_ok      (req_mem_ok),
      .cmd             (cmd),
      .status          (status),
      .rsp_result_kind (rsp_result_kind),
      .rsp_read_data   (rsp_read_data),
      .rsp_bus_error   (rsp_bus_error),
      .rsp_mem_address (rsp_mem_address),
      .rsp_burst_words (rsp_burst_words),
      .rsp_write_word  (rsp_write_word),
      .rsp_last        (rsp_last),
      .rsp_irq_level   (rsp_irq_level),
      .rsp_busy_res    (rsp_busy_res)
   );

endmodule

FILE: test/register_mapped_dma_copy_engine_test.sv
`timescale 1ns / 100ps

module register_mapped_dma_copy_engine_test;
   import dmac_pkg::*;

   // run limits: the slowest correct run stays far below this cycle count
   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int unsigned DRAIN_CYCLES = 40;
   localparam int unsigned PHASE_ITEMS  = 24;

   // clock, reset and the two channels
   logic        clock;
   logic        reset           = 1'b1;
   logic        req_valid       = 1'b0;
   logic        req_stall;
   logic [1:0]  req_command     = CMD_REG_READ;
   logic [5:0]  req_reg_offset  = OFF_SRC;
   logic [3:0]  req_access_size = SIZE_WORD;
   logic [31:0] req_write_data  = '0;
   logic [31:0] req_mem_word    = '0;
   logic        req_mem_ok      = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall       = 1'b0;
   logic [1:0]  rsp_result_kind;
   logic [31:0] rsp_read_data;
   logic        rsp_bus_error;
   logic [31:0] rsp_mem_address;
   logic [4:0]  rsp_burst_words;
   logic [31:0] rsp_write_word;
   logic        rsp_last;
   logic        rsp_irq_level;
   logic        rsp_busy_res;

   // one result transfer as the engine should present it
   typedef struct packed {
      dmac_kind_type kind;
      logic [31:0]   read_data;
      logic          bus_error;
      logic [31:0]   mem_address;
      logic [4:0]    burst_words;
      logic [31:0]   write_word;
      logic          last;
      logic          irq_level;
      logic          busy;
   } engine_output_type;

   engine_output_type outputs_due[$];    // predicted transfers not yet seen, oldest first
   engine_output_type step_outputs[$];   // transfers caused by the item being predicted
   engine_output_type due_output;

   // shadow copy of the engine state
   logic [31:0] shadow_src, shadow_dst, shadow_length, shadow_bias;
   logic        shadow_start, shadow_irq;
   logic [31:0] shadow_monitor [4];
   logic [31:0] shadow_read_cursor, shadow_write_cursor;
   logic [30:0] shadow_remaining;
   logic [31:0] shadow_buffer [BURST_WORDS];
   int unsigned shadow_fill;
   logic        shadow_failed;

   // bookkeeping
   int unsigned cycle_count        = 0;
   int unsigned items_sent         = 0;
   int unsigned mismatch_count     = 0;
   int unsigned sender_idle_pct    = 0;
   int unsigned receiver_stall_pct = 0;

   register_mapped_dma_copy_engine dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_command     (req_command),
      .req_reg_offset  (req_reg_offset),
      .req_access_size (req_access_size),
      .req_write_data  (req_write_data),
      .req_mem_word    (req_mem_word),
      .req_mem_ok      (req_mem_ok),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_kind (rsp_result_kind),
      .rsp_read_data   (rsp_read_data),
      .rsp_bus_error   (rsp_bus_error),
      .rsp_mem_address (rsp_mem_address),
      .rsp_burst_words (rsp_burst_words),
      .rsp_write_word  (rsp_write_word),
      .rsp_last        (rsp_last),
      .rsp_irq_level   (rsp_irq_level),
      .rsp_busy_res    (rsp_busy_res)
   );

   // 12 ns clock
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // watchdog: a hung engine or a lost transfer ends the run here
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** register_mapped_dma_copy_engine: FAILED **");
         $finish;
      end
   end

   // receiver back-pressure, changed on the falling edge only
   always @(negedge clock) begin
      rsp_stall = ($urandom_range(99) < receiver_stall_pct);
   end

   // ---------------------------------------------------------------- prediction

   // words asked for by the burst in flight
   function automatic int unsigned shadow_burst_len();
      if (shadow_remaining < 31'(BURST_WORDS))
         return int'(shadow_remaining);
      return BURST_WORDS;
   endfunction

   // start the next burst request, or close the copy and raise irq
   task automatic open_next_burst();
      engine_output_type o;
      shadow_fill   = 0;
      shadow_failed = 1'b0;
      if (shadow_remaining != 0) begin
         o             = '0;
         o.kind        = KIND_REQ;
         o.mem_address = shadow_read_cursor;
         o.burst_words = 5'(shadow_burst_len());
         step_outputs.push_back(o);
      end else begin
         shadow_start = 1'b0;
         shadow_irq   = 1'b1;
      end
   endtask

   // update the shadow state for one accepted item and queue its transfers
   task automatic compute_engine_outputs(input logic [1:0] cmd, input logic [5:0] off,
                                         input logic [3:0] size, input logic [31:0] wdata,
                                         input logic [31:0] mword, input logic mok);
      engine_output_type o;
      logic [31:0]    rd;
      logic           err;
      logic           kick;
      logic [3:0]     need;
      logic [32:0]    words;
      int unsigned    blen;
      int unsigned    mon;
      int unsigned    i;
      step_outputs.delete();
      rd   = '0;
      err  = 1'b0;
      kick = 1'b0;
      if (cmd == CMD_REG_READ || cmd == CMD_REG_WRITE) begin
         need = (off == OFF_CTL) ? SIZE_CTL : SIZE_WORD;
         if (off[1:0] != 2'b00 || off > OFF_MON4 || size != need) begin
            err = 1'b1;
         end else if (off == OFF_CTL) begin
            if (cmd == CMD_REG_WRITE) begin
               // start only from idle; a zero in the irq bit acknowledges
               if (wdata[CTL_START_BIT] && !shadow_start) begin
                  shadow_start = 1'b1;
                  kick         = 1'b1;
               end
               if (!wdata[CTL_IRQ_BIT] && shadow_irq)
                  shadow_irq = 1'b0;
            end else begin
               rd[CTL_START_BIT] = shadow_start;
               rd[CTL_IRQ_BIT]   = shadow_irq;
            end
         end else if (off < OFF_CTL) begin
            if (cmd == CMD_REG_WRITE) begin
               case (off)
                  OFF_SRC: shadow_src    = wdata;
                  OFF_DST: shadow_dst    = wdata;
                  OFF_LEN: shadow_length = wdata;
                  default: shadow_bias   = wdata;
               endcase
            end else begin
               case (off)
                  OFF_SRC: rd = shadow_src;
                  OFF_DST: rd = shadow_dst;
                  OFF_LEN: rd = shadow_length;
                  default: rd = shadow_bias;
               endcase
            end
         end else begin
            mon = (off - OFF_MON1) >> 2;
            if (cmd == CMD_REG_WRITE)
               shadow_monitor[mon] = wdata;
            else if (mon == 1)
               rd = shadow_monitor[mon];
            else
               rd = {24'h0, shadow_monitor[mon][7:0]};
         end
         o           = '0;
         o.kind      = KIND_REG;
         o.read_data = rd;
         o.bus_error = err;
         step_outputs.push_back(o);
         if (kick) begin
            words               = ({1'b0, shadow_length} + 33'(WORD_BYTES - 1)) / WORD_BYTES;
            shadow_read_cursor  = shadow_src;
            shadow_write_cursor = shadow_dst;
            shadow_remaining    = words[30:0];
            open_next_burst();
         end
      end else if (cmd == CMD_MEM_DATA && shadow_start) begin
         blen = shadow_burst_len();
         if (blen != 0 && shadow_fill < blen) begin
            shadow_buffer[shadow_fill] = mword;
            shadow_fill++;
            if (!mok)
               shadow_failed = 1'b1;
            if (shadow_fill == blen) begin
               // a burst with any bad word is dropped, cursors move on regardless
               if (!shadow_failed) begin
                  for (i = 0; i < blen; i++) begin
                     o             = '0;
                     o.kind        = KIND_WORD;
                     o.mem_address = shadow_write_cursor + 32'(i * WORD_BYTES);
                     o.write_word  = shadow_buffer[i];
                     step_outputs.push_back(o);
                  end
               end
               shadow_read_cursor  = shadow_read_cursor + 32'(blen * WORD_BYTES);
               shadow_write_cursor = shadow_write_cursor + 32'(blen * WORD_BYTES);
               shadow_remaining    = shadow_remaining - 31'(blen);
               open_next_burst();
            end
         end
      end
      // last, irq and busy reflect the state after the whole item
      foreach (step_outputs[k]) begin
         step_outputs[k].last      = (k == step_outputs.size() - 1);
         step_outputs[k].irq_level = shadow_irq;
         step_outputs[k].busy      = shadow_start;
         outputs_due.push_back(step_outputs[k]);
      end
   endtask

   // ---------------------------------------------------------------- checking

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $error("%s expected %h actual %h", name, want, got);
         mismatch_count++;
      end
   endtask

   // every accepted result transfer is matched against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (outputs_due.size() == 0) begin
            $error("result transfer with nothing expected, kind %0d", rsp_result_kind);
            mismatch_count++;
         end else begin
            due_output = outputs_due.pop_front();
            compare_field("result_kind", 32'(due_output.kind), 32'(rsp_result_kind));
            compare_field("read_data", due_output.read_data, rsp_read_data);
            compare_field("bus_error", 32'(due_output.bus_error), 32'(rsp_bus_error));
            compare_field("mem_address", due_output.mem_address, rsp_mem_address);
            compare_field("burst_words", 32'(due_output.burst_words), 32'(rsp_burst_words));
            compare_field("write_word", due_output.write_word, rsp_write_word);
            compare_field("last", 32'(due_output.last), 32'(rsp_last));
            compare_field("irq_level", 32'(due_output.irq_level), 32'(rsp_irq_level));
            compare_field("busy_res", 32'(due_output.busy), 32'(rsp_busy_res));
         end
      end
   end

   // ---------------------------------------------------------------- stimulus

   // one request transfer; valid stays high afterwards unless a gap follows
   task automatic send_item(input logic [1:0] cmd, input logic [5:0] off,
                            input logic [3:0] size, input logic [31:0] wdata,
                            input logic [31:0] mword, input logic mok);
      @(negedge clock);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_command     = cmd;
      req_reg_offset  = off;
      req_access_size = size;
      req_write_data  = wdata;
      req_mem_word    = mword;
      req_mem_ok      = mok;
      req_valid       = 1'b1;
      do
         @(posedge clock);
      while (req_stall);
      items_sent++;
      compute_engine_outputs(cmd, off, size, wdata, mword, mok);
   endtask

   function automatic logic [3:0] size_for(input logic [5:0] off);
      return (off == OFF_CTL) ? SIZE_CTL : SIZE_WORD;
   endfunction

   task automatic reg_write(input logic [5:0] off, input logic [31:0] data);
      send_item(CMD_REG_WRITE, off, size_for(off), data, $urandom, 1'($urandom));
   endtask

   task automatic reg_read(input logic [5:0] off);
      send_item(CMD_REG_READ, off, size_for(off), $urandom, $urandom, 1'($urandom));
   endtask

   // hold the request side until every predicted transfer has come out
   task automatic wait_for_quiet_engine();
      @(negedge clock);
      req_valid = 1'b0;
      while (outputs_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // anything at all: random command, offset, size and data
   task automatic send_noise();
      logic [1:0]  cmd;
      logic [5:0]  off;
      logic [3:0]  size;
      logic [31:0] wdata;
      cmd   = 2'($urandom_range(0, 3));
      off   = $urandom_range(1) ? 6'(4 * $urandom_range(0, 8)) : 6'($urandom_range(0, 63));
      size  = $urandom_range(1) ? size_for(off) : 4'($urandom_range(0, 15));
      wdata = $urandom;
      // never kick a copy from noise: its length may be anything
      if (cmd == CMD_REG_WRITE && off == OFF_CTL && !shadow_start)
         wdata[CTL_START_BIT] = 1'b0;
      send_item(cmd, off, size, wdata, $urandom, 1'($urandom));
   endtask

   // program, start, feed every burst, read the control register, then usually acknowledge the interrupt
   task automatic run_copy(input logic [31:0] src, input logic [31:0] dst,
                           input logic [31:0] len, input int unsigned fail_pct,
                           input int unsigned noise_pct);
      logic [31:0] ctl;
      reg_write(OFF_SRC, src);
      reg_write(OFF_DST, dst);
      reg_write(OFF_LEN, len);
      reg_write(OFF_BIAS, $urandom);
      ctl                = $urandom;
      ctl[CTL_START_BIT] = 1'b1;
      reg_write(OFF_CTL, ctl);
      while (shadow_start) begin
         if ($urandom_range(99) < noise_pct)
            send_noise();
         else
            send_item(CMD_MEM_DATA, 6'($urandom), 4'($urandom), $urandom, $urandom,
                      $urandom_range(99) >= fail_pct);
      end
      reg_read(OFF_CTL);
      ctl                = $urandom;
      ctl[CTL_START_BIT] = 1'b0;
      ctl[CTL_IRQ_BIT]   = ($urandom_range(3) == 0);
      reg_write(OFF_CTL, ctl);
   endtask

   // ---------------------------------------------------------------- tests

   // every register reads zero out of reset
   task automatic test_reset_state();
      int unsigned k;
      for (k = 0; k <= 8; k++)
         reg_read(6'(4 * k));
   endtask

   // register extremes, the narrowed monitor reads and the error decode
   task automatic test_register_file();
      reg_write(OFF_SRC, 32'hFFFF_FFFF);
      reg_read(OFF_SRC);
      reg_write(OFF_MON1, 32'hFFFF_FFFF);
      reg_write(OFF_MON2, 32'hFFFF_FFFF);
      reg_read(OFF_MON1);
      reg_read(OFF_MON2);
      // misaligned, beyond the map, and the top offset
      send_item(CMD_REG_READ, 6'd2, SIZE_WORD, '0, '0, 1'b0);
      send_item(CMD_REG_WRITE, 6'd36, SIZE_WORD, 32'hFFFF_FFFF, '0, 1'b0);
      send_item(CMD_REG_READ, 6'd63, 4'd15, '0, '0, 1'b1);
      // wrong sizes change nothing, a word-sized control write does not start
      send_item(CMD_REG_WRITE, OFF_SRC, 4'd0, '0, '0, 1'b0);
      send_item(CMD_REG_WRITE, OFF_SRC, 4'd8, '0, '0, 1'b0);
      send_item(CMD_REG_WRITE, OFF_CTL, SIZE_WORD, 32'h0000_0001, '0, 1'b0);
      reg_read(OFF_SRC);
      reg_write(OFF_SRC, '0);
   endtask

   // zero length finishes at once; irq bit written as one does not clear
   task automatic test_zero_length();
      reg_write(OFF_LEN, '0);
      reg_write(OFF_CTL, 32'h0000_0001);
      reg_write(OFF_CTL, 32'h0000_0010);
      reg_read(OFF_CTL);
      reg_write(OFF_CTL, 32'h0000_0000);
      reg_read(OFF_CTL);
   endtask

   // a memory word while idle and the unused command give nothing back
   task automatic test_ignored_items();
      send_item(CMD_MEM_DATA, '0, '0, '0, 32'hFFFF_FFFF, 1'b1);
      send_item(2'd3, 6'h3F, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
   endtask

   // address wrap, a two-burst copy with busy register traffic, a dropped final burst
   task automatic test_copy_cases();
      run_copy(32'hFFFF_FFFC, 32'hFFFF_FFF8, 32'd9, 0, 0);
      run_copy($urandom, $urandom, 32'd65, 10, 30);
      run_copy($urandom, $urandom, 32'd8, 100, 0);
   endtask

   // mostly complete copies with random content, the rest noise
   task automatic test_random_traffic();
      int unsigned phase;
      int unsigned target;
      logic [31:0] src;
      logic [31:0] dst;
      logic [31:0] len;
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 45; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 45; end
            default: begin sender_idle_pct = 37; receiver_stall_pct = 37; end
         endcase
         // let the engine run dry once before this phase
         if (phase == 2)
            wait_for_quiet_engine();
         target = items_sent + PHASE_ITEMS;
         while (items_sent < target) begin
            if ($urandom_range(99) < 80) begin
               src = ($urandom_range(7) == 0) ? (32'hFFFF_FF00 | 32'($urandom_range(255)))
                                              : $urandom;
               dst = ($urandom_range(7) == 0) ? (32'hFFFF_FF00 | 32'($urandom_range(255)))
                                              : $urandom;
               case ($urandom_range(9))
                  0: len = '0;
                  1: len = 32'd64;
                  2: len = 32'd65;
                  default: len = 32'($urandom_range(1, 72));
               endcase
               run_copy(src, dst, len, 8, 15);
            end else begin
               repeat ($urandom_range(1, 4)) send_noise();
            end
         end
      end
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
   endtask

   // largest length: two full bursts go through, the copy is left running
   task automatic test_full_length();
      int unsigned k;
      reg_write(OFF_LEN, 32'hFFFF_FFFF);
      reg_write(OFF_CTL, 32'h0000_0001);
      for (k = 0; k < 2 * BURST_WORDS; k++)
         send_item(CMD_MEM_DATA, '0, '0, '0, $urandom, 1'b1);
      reg_read(OFF_CTL);
   endtask

   initial begin
      // synchronous reset, then released on a falling edge
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_state();
      test_register_file();
      test_zero_length();
      test_ignored_items();
      test_copy_cases();
      test_random_traffic();
      test_full_length();

      wait_for_quiet_engine();
      if (mismatch_count == 0)
         $display("** register_mapped_dma_copy_engine: PASSED **");
      else
         $display("** register_mapped_dma_copy_engine: FAILED **");
      $finish;
   end

endmodule
